FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under synchronous reset.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under synchronous reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/fnr_pkg.sv
package fnr_pkg;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic gcd_step;
    logic div_init;
    logic div_sel_b;
    logic div_step;
    logic take_a;
    logic take_b;
    logic out_load;
  } fnr_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic special;
    logic gcd_eq;
    logic div_last;
  } fnr_status_t;

endpackage

FILE: rtl/core/fnr_if.sv
interface fnr_in_if #(
  parameter int WORD_BITS = 32
);
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] numerator_in;
  logic [WORD_BITS-1:0] denominator_in;

  modport source (output valid, output numerator_in, output denominator_in, input ready);
  modport sink   (input valid, input numerator_in, input denominator_in, output ready);
endinterface

interface fnr_out_if #(
  parameter int WORD_BITS = 32
);
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] numerator_out;
  logic [WORD_BITS-2:0] denominator_out;
  logic                 error;

  modport source (output valid, output numerator_out, output denominator_out,
                  output error, input ready);
  modport sink   (input valid, input numerator_out, input denominator_out,
                  input error, output ready);
endinterface

FILE: rtl/core/fnr_ctrl.sv
module fnr_ctrl import fnr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  fnr_status_t status,
  output fnr_cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_GCD  = 5'b00010,
    S_DIVA = 5'b00100,
    S_DIVB = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_GCD;
        end
      end
      S_GCD: begin
        if (status.special) begin
          state_next = S_DONE;
        end else if (status.gcd_eq) begin
          cmd.div_init = 1'b1;
          state_next   = S_DIVA;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_DIVA: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          // capture the numerator quotient and restart on the denominator
          cmd.take_a    = 1'b1;
          cmd.div_init  = 1'b1;
          cmd.div_sel_b = 1'b1;
          state_next    = S_DIVB;
        end
      end
      S_DIVB: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          cmd.take_b = 1'b1;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

FILE: rtl/core/fnr_datapath.sv
module fnr_datapath import fnr_pkg::*; #(
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  fnr_cmd_t             cmd,
  output fnr_status_t          status,
  input  logic [WORD_BITS-1:0] numerator,
  input  logic [WORD_BITS-1:0] denominator,
  output logic [WORD_BITS-1:0] res_num,
  output logic [WORD_BITS-2:0] res_den,
  output logic                 res_err
);

  localparam int M  = WORD_BITS - 1;
  localparam int CW = $clog2(M);

  localparam logic [WORD_BITS-1:0] MOST_NEG = {1'b1, {M{1'b0}}};
  localparam logic [CW-1:0]        LAST_CNT = CW'(M - 1);

  logic          neg;
  logic          err_f;
  logic          zero_f;
  logic [M-1:0]  na;
  logic [M-1:0]  nb;
  logic [M-1:0]  ga;
  logic [M-1:0]  gb;
  logic [CW-1:0] k;
  logic [M-1:0]  rem;
  logic [M-1:0]  quo;
  logic [CW-1:0] cnt;
  logic [M-1:0]  qa;
  logic [M-1:0]  qb;

  logic          ld_err;
  logic [M-1:0]  mag_x;
  logic [M-1:0]  mag_y;
  logic [M-1:0]  diff;
  logic [M-1:0]  g;
  logic [M:0]    trial;
  logic          fits;
  logic [M-1:0]  rem_step;
  logic [M-1:0]  quo_step;
  logic [WORD_BITS-1:0] num_mag;

  assign ld_err = (denominator == '0) || (numerator == MOST_NEG) || (denominator == MOST_NEG);
  assign mag_x  = numerator[WORD_BITS-1]   ? M'(~numerator + 1'b1)   : numerator[M-1:0];
  assign mag_y  = denominator[WORD_BITS-1] ? M'(~denominator + 1'b1) : denominator[M-1:0];

  assign diff = (ga > gb) ? (ga - gb) : (gb - ga);
  assign g    = ga << k;

  // restoring division, one quotient bit per step
  assign trial    = {rem, quo[M-1]};
  assign fits     = trial >= {1'b0, g};
  assign rem_step = fits ? M'(trial - {1'b0, g}) : trial[M-1:0];
  assign quo_step = {quo[M-2:0], fits};

  assign status.special  = err_f || zero_f;
  assign status.gcd_eq   = (ga == gb);
  assign status.div_last = (cnt == LAST_CNT);

  assign num_mag = {1'b0, qa};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg    <= numerator[WORD_BITS-1] ^ denominator[WORD_BITS-1];
      err_f  <= ld_err;
      zero_f <= (numerator == '0);
      na     <= mag_x;
      nb     <= mag_y;
      ga     <= mag_x;
      gb     <= mag_y;
      k      <= '0;
    end else if (cmd.gcd_step) begin
      // binary gcd step
      if (!ga[0] && !gb[0]) begin
        ga <= ga >> 1;
        gb <= gb >> 1;
        k  <= k + 1'b1;
      end else if (!ga[0]) begin
        ga <= ga >> 1;
      end else if (!gb[0]) begin
        gb <= gb >> 1;
      end else if (ga > gb) begin
        ga <= diff >> 1;
      end else begin
        gb <= diff >> 1;
      end
    end

    if (cmd.div_init) begin
      rem <= '0;
      quo <= cmd.div_sel_b ? nb : na;
      cnt <= '0;
    end else if (cmd.div_step) begin
      rem <= rem_step;
      quo <= quo_step;
      cnt <= cnt + 1'b1;
    end

    if (cmd.take_a) begin
      qa <= quo_step;
    end
    if (cmd.take_b) begin
      qb <= quo_step;
    end

    if (cmd.out_load) begin
      res_err <= err_f;
      if (err_f) begin
        res_num <= '0;
        res_den <= '0;
      end else if (zero_f) begin
        res_num <= '0;
        res_den <= M'(1);
      end else begin
        res_num <= neg ? (~num_mag + 1'b1) : num_mag;
        res_den <= qb;
      end
    end
  end

endmodule

FILE: rtl/core/fraction_normalize_reduce_core.sv
// Fraction reducer: takes a signed numerator and denominator, moves the sign
// onto the numerator and divides both by their greatest common divisor, giving
// the fraction in lowest terms over a positive denominator. A zero
// denominator, or either operand at the most negative value, yields 0/0 with
// error set; a zero numerator yields 0/1. One fraction is worked at a time:
// a binary GCD loop runs first, then a shared restoring divider forms the
// numerator quotient and then the denominator quotient, and the result is
// loaded; error and zero cases skip the loop and the divider. The result sits
// in an output register, so the next fraction is accepted while the previous
// result waits to be taken.
`include "assert_macros.svh"

module fraction_normalize_reduce_core import fnr_pkg::*; #(
  parameter int WORD_BITS = 32
) (
  input  logic      clk,
  input  logic      rst,
  fnr_in_if.sink    operands,
  fnr_out_if.source result
);

  fnr_cmd_t    cmd;
  fnr_status_t status;

  // Sequencer: accept a beat, run gcd, run both divisions, load the result.
  fnr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (operands.valid),
    .in_ready  (operands.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Operand registers, gcd unit, shared divider and output register.
  fnr_datapath #(
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk         (clk),
    .cmd         (cmd),
    .status      (status),
    .numerator   (operands.numerator_in),
    .denominator (operands.denominator_in),
    .res_num     (result.numerator_out),
    .res_den     (result.denominator_out),
    .res_err     (result.error)
  );

  // An errored beat carries 0/0.
  `ASSERT_SAME(a_err_zero, clk, rst, result.valid && result.error, (result.numerator_out == '0) && (result.denominator_out == '0), "error result not 0/0")

  // A good beat always has a nonzero denominator.
  `ASSERT_SAME(a_den_nonzero, clk, rst, result.valid && !result.error, result.denominator_out != '0, "zero denominator on good result")

  // Hold off new operands while one is being worked.
  `ASSERT_NEXT(a_one_at_a_time, clk, rst, operands.valid && operands.ready, !operands.ready, "operand accepted while busy")

endmodule
